// File: src/swds_pkg.sv
// shared constants, widths and control/status types for the wendland density sum block
// no dependencies

package swds_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int MUL_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SQ_W      = 2 * DATA_W;
  localparam int ROOT_W    = DATA_W + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int SUM_W     = 48;
  localparam int U_W       = FRAC_BITS + 1;
  localparam int TQ_W      = FRAC_BITS + 3;
  localparam int TERM_W    = DATA_W + 3;
  localparam int CFG_IDX_W = 8;

  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [DATA_W-1:0] INV_RESET = DATA_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEST_X      = 8'd0,
    CFG_TEST_Y      = 8'd1,
    CFG_INV_SMOOTH  = 8'd2,
    CFG_KERNEL_COEF = 8'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_SQX,
    MUL_SQY,
    MUL_DQ,
    MUL_UU,
    MUL_U2,
    MUL_WQ,
    MUL_T
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sx_load;
    logic     sqrt_start;
    logic     q_load;
    logic     acc_en;
    logic     emit;
  } swds_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic in_support;
    logic last;
    logic out_free;
  } swds_status_t;

endpackage

// File: src/sph_wendland_density_sum.sv
// top level of the 2d wendland kernel density sum: controller plus datapath
// depends on swds_pkg, swds_ctrl, swds_dpath
//
// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata[31:0] pos_x, tdata[63:32] pos_y, tlast last
// out_    | out | out_tvalid/tready   | tdata[47:0] density_sum, tuser saturated
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index register index, cfg_data value
//
// one particle at a time: each item runs through the 33-step square root and up to seven
// passes through the single shared 33x33 multiplier (four are skipped outside the support)
// an item marked last also passes through an emit state that loads the output register
// while the output register still holds an unaccepted result, the next emission waits
// and input stays blocked until it is taken
// synchronous active-low reset clears sum, saturation flag and config to defaults

module sph_wendland_density_sum
  import swds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*DATA_W-1:0]  in_tdata,   // pos_x, pos_y
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SUM_W-1:0]     out_tdata,  // density_sum
  output logic                 out_tuser,  // saturated
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  swds_cmd_t    cmd;
  swds_status_t st;

  assign cfg_ready = 1'b1;

  swds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  swds_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // no second item while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // emission never overwrites a result still waiting
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("emission over pending result");

  // saturated flag only with a clamped sum
  a_sat_means_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == SUM_MAX)
    else $error("saturated without full-scale sum");

  // square root finishes only while an item is in flight
  a_sqrt_then_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    st.sqrt_done |-> !in_tready)
    else $error("square root finished while idle");

endmodule

// File: src/swds_isqrt.sv
// iterative integer square root, one root bit per cycle, restoring recurrence
// depends on swds_pkg

module swds_isqrt
  import swds_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  rem_t;
  logic [REM_W+1:0]  trial;
  logic              ge;

  always_comb begin
    rem_t    = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({root_r, 2'b01});
    ge       = rem_t >= trial;
    rem_nxt  = ge ? REM_W'(rem_t - trial) : REM_W'(rem_t);
    root_nxt = {root_r[ROOT_W-2:0], ge};
    rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && cnt_r == '0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= STEP_W'(ROOT_W - 1);
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// File: src/swds_dpath.sv
// datapath: config registers, shared multiplier, square root unit, accumulator, output register
// depends on swds_pkg and swds_isqrt

module swds_dpath
  import swds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic [2*DATA_W-1:0]  in_tdata,
  input  logic                 in_tlast,
  input  swds_cmd_t            cmd,
  output swds_status_t         st,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SUM_W-1:0]     out_tdata,
  output logic                 out_tuser
);

  logic [DATA_W-1:0] test_x_r, test_y_r, inv_r, coeff_r;
  logic [DATA_W-1:0] ax_r, ay_r;
  logic              last_r;
  logic [SQ_W-1:0]   sx_r;
  logic [PROD_W-1:0] prod_r;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [U_W-1:0]    u_r;
  logic [TQ_W-1:0]   tq_r;
  logic              in_support_r;
  logic [SUM_W-1:0]  sum_r;
  logic              ovf_r;
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_sat_r;

  logic [DATA_W:0]   dx, dy;
  logic [ROOT_W-1:0] root;
  logic              sqrt_done;
  logic [RAD_W-1:0]  radicand;
  logic              in_support;
  logic [U_W-1:0]    q;
  logic [MUL_W-1:0]  prod_sh;
  logic [TERM_W-1:0] term;
  logic [SUM_W:0]    sum_ext;

  swds_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (radicand),
    .root     (root),
    .done     (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_x_r <= '0;
      test_y_r <= '0;
      inv_r    <= INV_RESET;
      coeff_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEST_X:      test_x_r <= cfg_data;
        CFG_TEST_Y:      test_y_r <= cfg_data;
        CFG_INV_SMOOTH:  inv_r    <= cfg_data;
        CFG_KERNEL_COEF: coeff_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx         = {test_x_r[DATA_W-1], test_x_r} - {in_tdata[DATA_W-1], in_tdata[DATA_W-1:0]};
    dy         = {test_y_r[DATA_W-1], test_y_r}
                 - {in_tdata[2*DATA_W-1], in_tdata[2*DATA_W-1:DATA_W]};
    radicand   = RAD_W'(sx_r) + RAD_W'(prod_r[SQ_W-1:0]);
    in_support = prod_r[PROD_W-1:2*FRAC_BITS+1] == '0;
    q          = prod_r[2*FRAC_BITS:FRAC_BITS];
    prod_sh    = prod_r[FRAC_BITS+MUL_W-1:FRAC_BITS];
    term       = prod_r[FRAC_BITS+TERM_W-1:FRAC_BITS];
    sum_ext    = {1'b0, sum_r} + (SUM_W+1)'(term);
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_SQX: begin mul_a = MUL_W'(ax_r);      mul_b = MUL_W'(ax_r);      end
      MUL_SQY: begin mul_a = MUL_W'(ay_r);      mul_b = MUL_W'(ay_r);      end
      MUL_DQ:  begin mul_a = root;              mul_b = MUL_W'(inv_r);     end
      MUL_UU:  begin mul_a = MUL_W'(u_r);       mul_b = MUL_W'(u_r);       end
      MUL_U2:  begin mul_a = prod_sh;           mul_b = prod_sh;           end
      MUL_WQ:  begin mul_a = prod_sh;           mul_b = MUL_W'(tq_r);      end
      MUL_T:   begin mul_a = MUL_W'(coeff_r);   mul_b = prod_sh;           end
      default: begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r   <= dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
      ay_r   <= dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
      last_r <= in_tlast;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.sx_load) begin
      sx_r <= prod_r[SQ_W-1:0];
    end
    if (cmd.q_load) begin
      in_support_r <= in_support;
      u_r          <= U_W'(1 << FRAC_BITS) - U_W'(q[U_W-1:1]);
      tq_r         <= TQ_W'({q, 1'b0}) + TQ_W'(1 << FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.acc_en && in_support_r) begin
        if (sum_ext[SUM_W]) begin
          sum_r <= SUM_MAX;
          ovf_r <= 1'b1;
        end else begin
          sum_r <= sum_ext[SUM_W-1:0];
        end
      end else if (cmd.emit) begin
        sum_r <= '0;
        ovf_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sum_r <= sum_r;
      out_sat_r <= ovf_r;
    end
  end

  assign st.sqrt_done  = sqrt_done;
  assign st.in_support = in_support;
  assign st.last       = last_r;
  assign st.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_sat_r;

endmodule

// File: src/swds_ctrl.sv
// controller state machine sequencing one particle through the datapath
// depends on swds_pkg

module swds_ctrl
  import swds_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  swds_status_t st,
  output swds_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_WAIT,
    S_MULQ,
    S_QCHK,
    S_UU,
    S_U4,
    S_W,
    S_T,
    S_ACC,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.mul_sel = MUL_SQX;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_rdy_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_SQY;
      end
      S_SQY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQY;
        cmd.sx_load = 1'b1;
        state_nxt   = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (st.sqrt_done) begin
          state_nxt = S_MULQ;
        end
      end
      S_MULQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DQ;
        state_nxt   = S_QCHK;
      end
      S_QCHK: begin
        cmd.q_load = 1'b1;
        state_nxt  = st.in_support ? S_UU : S_ACC;
      end
      S_UU: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_UU;
        state_nxt   = S_U4;
      end
      S_U4: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_U2;
        state_nxt   = S_W;
      end
      S_W: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WQ;
        state_nxt   = S_T;
      end
      S_T: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = st.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_rdy_r <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      in_rdy_r <= state_nxt == S_IDLE;
    end
  end

  assign in_tready = in_rdy_r;

endmodule
